### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the Gaussian density block.
// Plain text macros; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert a property that must also hold while reset is applied.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/dgd_pkg.sv
// Package for the diagonal Gaussian density block: sizes, fixed-point
// constants, status codes and the elaboration-time exp table. No dependencies.
package dgd_pkg;

  localparam int MAX_DIMS       = 16;
  localparam int EXP_TABLE_BITS = 6;
  localparam int EXP_N          = 1 << EXP_TABLE_BITS;
  localparam int FRAC_SHIFT     = 16 - EXP_TABLE_BITS;
  localparam int DCW            = $clog2(MAX_DIMS + 1);

  localparam longint unsigned SCALE_E9 = 64'd1000000000;
  localparam logic [32:0] INV_SQRT_2PI_Q32 = 33'((64'd398942280 << 32) / SCALE_E9);
  localparam logic [32:0] HALF_LOG2E_Q32   = 33'((64'd721347520 << 32) / SCALE_E9);
  localparam logic [47:0] SUM_MAX          = '1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TOO_MANY = 2'd1;
  localparam logic [1:0] STATUS_ZERO_INV = 2'd2;

  localparam longint unsigned POW2_ROOT_E9 [0:9] = '{
    64'd707106781, 64'd840896415, 64'd917004043, 64'd957603281, 64'd978572062,
    64'd989228013, 64'd994594434, 64'd997296056, 64'd998647113, 64'd999323328
  };

  typedef logic [32:0] exp_tab_t [0:EXP_N];

  // Build 2^(-j/N) in Q1.32 from the per-bit root factors.
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t         t;
    longint unsigned  acc;
    longint unsigned  c;
    for (int j = 0; j < EXP_N; j++) begin
      acc = 64'd1 << 32;
      for (int i = 1; i <= EXP_TABLE_BITS; i++) begin
        if (((j >> (EXP_TABLE_BITS - i)) & 1) != 0) begin
          c   = (POW2_ROOT_E9[i-1] << 32) / SCALE_E9;
          acc = (acc * c) >> 32;
        end
      end
      t[j] = acc[32:0];
    end
    t[EXP_N] = 33'h0_8000_0000;
    return t;
  endfunction

endpackage

### hw/rtl/diagonal_gaussian_density.sv
// Diagonal Gaussian density: accumulates one dimension per input transfer
// and emits the density on the last one. Depends on dgd_pkg, assert_macros.svh.
//
// Usage: each input transfer (in_valid/in_ready) carries one dimension of a
// point: coordinate, mean, reciprocal deviation (Q16.16) and is_last. An
// input transfer with is_last set produces one output transfer (out_valid/
// out_ready) with the density (Q16.16, saturating), the dimension count and
// a status code; other input transfers produce nothing.
// One shared 33x33 multiplier under a sequencer does all the math.
// A dimension runs through the multiply and accumulate steps from its
// transfer to the next in_ready (and skips them when it is over the
// dimension limit). The last dimension adds a 1/sqrt(2*pi) scaling step
// per accumulated dimension, then the exponent, table interpolation, final
// scaling and hand-off. Errored points skip the density math.
// in_ready is high only while the sequencer is idle. A finished result
// waits in the output register; a new point may start meanwhile, and the
// sequencer holds its next result until the receiver takes the old one.
// Reset (rst_n low, synchronous) clears the accumulators and drops any
// pending result.
`include "assert_macros.svh"

module diagonal_gaussian_density
  import dgd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_coordinate,
  input  logic signed [31:0] in_mean,
  input  logic [31:0]        in_inv_std_dev,
  input  logic               in_is_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_density,
  output logic [4:0]         out_dims_used,
  output logic [1:0]         out_status
);

  typedef enum logic [4:0] {
    S_IDLE, S_Z, S_SQ, S_ACC, S_PLO, S_PUPD, S_CHECK,
    S_VHI, S_VLO, S_VUPD, S_WHI, S_WLO, S_WUPD, S_M, S_MUPD,
    S_DHI, S_DLO, S_DUPD, S_FIN
  } state_t;

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  state_t                    state_r, state_nxt;
  logic [31:0]               absd_r, absd_nxt;
  logic [31:0]               inv_r, inv_nxt;
  logic                      last_r, last_nxt;
  logic [47:0]               sum_r, sum_nxt;
  logic [63:0]               prod_r, prod_nxt;
  logic [DCW-1:0]            dim_r, dim_nxt;
  logic [1:0]                err_r, err_nxt;
  logic [DCW-1:0]            cnt_r, cnt_nxt;
  logic [63:0]               t_r, t_nxt;
  logic [63:0]               v_r, v_nxt;
  logic [31:0]               k_r, k_nxt;
  logic [EXP_TABLE_BITS-1:0] idx_r, idx_nxt;
  logic [FRAC_SHIFT-1:0]     rem_r, rem_nxt;
  logic [32:0]               m_r, m_nxt;
  logic [65:0]               mul_r;
  logic [31:0]               fin_dens_r, fin_dens_nxt;
  logic [1:0]                fin_stat_r, fin_stat_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [31:0]               out_dens_r, out_dens_nxt;
  logic [4:0]                out_dims_r, out_dims_nxt;
  logic [1:0]                out_stat_r, out_stat_nxt;

  logic [32:0]               op_a, op_b;
  logic signed [32:0]        diff;
  logic [31:0]               z_sat;
  logic [48:0]               sum_add;
  logic [64:0]               prod_add;
  logic [47:0]               w_val;
  logic [63:0]               d_val;
  logic [32:0]               tab_lo, tab_hi;
  logic [EXP_TABLE_BITS:0]   idx_next;

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_density   = out_dens_r;
  assign out_dims_used = out_dims_r;
  assign out_status    = out_stat_r;

  // Datapath helpers around the shared multiplier result
  assign diff     = {in_coordinate[31], in_coordinate} - {in_mean[31], in_mean};
  assign z_sat    = (mul_r[65:48] != '0) ? 32'hFFFF_FFFF : mul_r[47:16];
  assign sum_add  = {1'b0, sum_r} + {1'b0, mul_r[63:16]};
  assign prod_add = {1'b0, t_r[47:0], 16'd0} + {17'd0, mul_r[63:16]};
  assign w_val    = t_r[47:0] + {16'd0, mul_r[63:32]};
  assign d_val    = t_r + {32'd0, mul_r[63:32]};
  assign idx_next = {1'b0, idx_r} + 1'b1;
  assign tab_lo   = EXP_TAB[idx_r];
  assign tab_hi   = EXP_TAB[idx_next];

  // Select the multiplier operands for the current step
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      S_Z:             begin op_a = {1'b0, absd_r};        op_b = {1'b0, inv_r}; end
      S_SQ:            begin op_a = {1'b0, z_sat};         op_b = {1'b0, z_sat}; end
      S_ACC:           begin op_a = {1'b0, prod_r[63:32]}; op_b = {1'b0, inv_r}; end
      S_PLO:           begin op_a = {1'b0, prod_r[31:0]};  op_b = {1'b0, inv_r}; end
      S_VHI:           begin op_a = {1'b0, v_r[63:32]};    op_b = INV_SQRT_2PI_Q32; end
      S_VLO:           begin op_a = {1'b0, v_r[31:0]};     op_b = INV_SQRT_2PI_Q32; end
      S_WHI:           begin op_a = {17'd0, sum_r[47:32]}; op_b = HALF_LOG2E_Q32; end
      S_WLO:           begin op_a = {1'b0, sum_r[31:0]};   op_b = HALF_LOG2E_Q32; end
      S_M:             begin op_a = tab_lo - tab_hi;
                             op_b = 33'(rem_r); end
      S_DHI:           begin op_a = {1'b0, v_r[63:32]};    op_b = m_r; end
      S_DLO:           begin op_a = {1'b0, v_r[31:0]};     op_b = m_r; end
      default:         begin op_a = '0;                    op_b = '0; end
    endcase
  end

  // Sequencer next-state and register updates
  always_comb begin
    state_nxt     = state_r;
    absd_nxt      = absd_r;
    inv_nxt       = inv_r;
    last_nxt      = last_r;
    sum_nxt       = sum_r;
    prod_nxt      = prod_r;
    dim_nxt       = dim_r;
    err_nxt       = err_r;
    cnt_nxt       = cnt_r;
    t_nxt         = t_r;
    v_nxt         = v_r;
    k_nxt         = k_r;
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    m_nxt         = m_r;
    fin_dens_nxt  = fin_dens_r;
    fin_stat_nxt  = fin_stat_r;
    out_valid_nxt = out_valid_r;
    out_dens_nxt  = out_dens_r;
    out_dims_nxt  = out_dims_r;
    out_stat_nxt  = out_stat_r;

    // Drop the result once the receiver takes it
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          absd_nxt = diff[32] ? 32'(-diff) : diff[31:0];
          inv_nxt  = in_inv_std_dev;
          last_nxt = in_is_last;
          if (32'(dim_r) >= 32'(MAX_DIMS)) begin
            err_nxt   = err_r | 2'b01;
            state_nxt = S_CHECK;
          end else begin
            dim_nxt   = dim_r + 1'b1;
            if (in_inv_std_dev == '0) begin
              err_nxt = err_r | 2'b10;
            end
            state_nxt = S_Z;
          end
        end
      end
      S_Z:   state_nxt = S_SQ;
      S_SQ:  state_nxt = S_ACC;
      S_ACC: begin
        sum_nxt   = sum_add[48] ? SUM_MAX : sum_add[47:0];
        state_nxt = S_PLO;
      end
      S_PLO: begin
        t_nxt     = mul_r[63:0];
        state_nxt = S_PUPD;
      end
      S_PUPD: begin
        if (t_r[63:48] != '0 || prod_add[64]) begin
          prod_nxt = '1;
        end else begin
          prod_nxt = prod_add[63:0];
        end
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (err_r != 2'b00) begin
          fin_dens_nxt = '0;
          fin_stat_nxt = err_r[0] ? STATUS_TOO_MANY : STATUS_ZERO_INV;
          state_nxt    = S_FIN;
        end else begin
          fin_stat_nxt = STATUS_OK;
          v_nxt        = prod_r;
          cnt_nxt      = dim_r;
          state_nxt    = S_VHI;
        end
      end
      // Scale by 1/sqrt(2*pi) once per dimension
      S_VHI: state_nxt = (cnt_r == '0) ? S_WHI : S_VLO;
      S_VLO: begin
        t_nxt     = mul_r[63:0];
        state_nxt = S_VUPD;
      end
      S_VUPD: begin
        v_nxt     = d_val;
        cnt_nxt   = cnt_r - 1'b1;
        state_nxt = S_VHI;
      end
      // Exponent w = sum * log2(e)/2
      S_WHI: state_nxt = S_WLO;
      S_WLO: begin
        t_nxt     = mul_r[63:0];
        state_nxt = S_WUPD;
      end
      S_WUPD: begin
        k_nxt     = w_val[47:16];
        idx_nxt   = w_val[15:FRAC_SHIFT];
        rem_nxt   = w_val[FRAC_SHIFT-1:0];
        state_nxt = S_M;
      end
      S_M: state_nxt = S_MUPD;
      S_MUPD: begin
        m_nxt     = tab_lo - mul_r[FRAC_SHIFT+32:FRAC_SHIFT];
        state_nxt = S_DHI;
      end
      S_DHI: state_nxt = S_DLO;
      S_DLO: begin
        t_nxt     = mul_r[63:0];
        state_nxt = S_DUPD;
      end
      S_DUPD: begin
        if (k_r >= 32'd64) begin
          fin_dens_nxt = '0;
        end else if ((d_val >> k_r[5:0]) > 64'h0000_0000_FFFF_FFFF) begin
          fin_dens_nxt = 32'hFFFF_FFFF;
        end else begin
          fin_dens_nxt = 32'(d_val >> k_r[5:0]);
        end
        state_nxt = S_FIN;
      end
      // Hand the result over once the output register is free, and clear the point
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_dens_nxt  = fin_dens_r;
          out_stat_nxt  = fin_stat_r;
          out_dims_nxt  = (32'(dim_r) > 32'd31) ? 5'd31 : 5'(dim_r);
          sum_nxt       = '0;
          prod_nxt      = 64'd65536;
          dim_nxt       = '0;
          err_nxt       = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state, accumulators and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      prod_r      <= 64'd65536;
      dim_r       <= '0;
      err_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      prod_r      <= prod_nxt;
      dim_r       <= dim_nxt;
      err_r       <= err_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    absd_r     <= absd_nxt;
    inv_r      <= inv_nxt;
    last_r     <= last_nxt;
    t_r        <= t_nxt;
    v_r        <= v_nxt;
    k_r        <= k_nxt;
    idx_r      <= idx_nxt;
    rem_r      <= rem_nxt;
    m_r        <= m_nxt;
    mul_r      <= op_a * op_b;
    fin_dens_r <= fin_dens_nxt;
    fin_stat_r <= fin_stat_nxt;
    out_dens_r <= out_dens_nxt;
    out_dims_r <= out_dims_nxt;
    out_stat_r <= out_stat_nxt;
  end

  `ASSERT_CLK(a_dim_limit, clk, rst_n, 32'(dim_r) <= 32'(MAX_DIMS), "dimension count over limit")
  `ASSERT_CLK(a_err_skips_math, clk, rst_n, (state_r == S_VHI) |-> (err_r == 2'b00), "density math on errored point")
  `ASSERT_CLK(a_fin_no_overwrite, clk, rst_n, (state_r == S_FIN && out_valid_r && !out_ready) |=> (state_r == S_FIN), "result overwritten while stalled")
  `ASSERT_CLK(a_status_code, clk, rst_n, out_valid_r |-> (out_stat_r == STATUS_OK || out_stat_r == STATUS_TOO_MANY || out_stat_r == STATUS_ZERO_INV), "bad status code")

endmodule
